>>> rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

  // Operation selectors
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_NULL  = 2'd3;

  // Width of the reported count
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        item_handle;
    logic [15:0]        item_kind;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_handle;
    logic [15:0]        out_kind;
    logic signed [31:0] out_priority;
    logic               found;
    logic [COUNT_W-1:0] count;
  } out_t;

  // One stored entry
  typedef struct packed {
    logic [31:0]        handle;
    logic [15:0]        kind;
    logic signed [31:0] prio;
  } entry_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic capture;    // register compare flags against the incoming transaction
    logic do_insert;  // open a slot at the insert point and shift the tail up
    logic do_remove;  // shift every entry one place towards the head
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

>>> rtl/spq_cell.sv
// One cell of the sorted chain: holds a single entry and its compare flags.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  spq_pkg::entry_t   cmp_entry,
  input  spq_pkg::entry_t   ins_entry,
  input  spq_pkg::entry_t   prev_entry,
  input  spq_pkg::entry_t   next_entry,
  input  logic              prev_ins,
  output spq_pkg::entry_t   entry,
  output logic              ins,
  output logic              match
);

  spq_pkg::entry_t entry_r, entry_nxt;
  logic            ins_r, ins_nxt;
  logic            match_r, match_nxt;

  // Compare flags: this cell lies at or past the insert point, or holds the handle
  always_comb begin
    ins_nxt   = ins_r;
    match_nxt = match_r;
    if (ctl.capture) begin
      ins_nxt   = !occ || ($signed(entry_r.prio) > $signed(cmp_entry.prio));
      match_nxt = occ && (entry_r.handle == cmp_entry.handle);
    end
  end

  // Entry movement: first cell past the insert point takes the new entry,
  // later ones take their lower neighbour; remove pulls from the upper neighbour
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_insert) begin
      if (prev_ins) begin
        entry_nxt = prev_entry;
      end else if (ins_r) begin
        entry_nxt = ins_entry;
      end
    end else if (ctl.do_remove) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    ins_r   <= ins_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign ins   = ins_r;
  assign match = match_r;

endmodule

>>> rtl/stable_priority_queue_unit.sv
// Stable minimum priority queue: a row of CAPACITY cells kept in ascending
// priority order, equal priorities first in first out. In the cycle a
// transaction is accepted every cell compares its entry with the incoming
// one, and in the next cycle the row shifts (insert or remove) and the
// result is loaded into the output register. No new transaction is taken
// while one executes or while a held result is stalled. No clearing pass
// is needed after reset; occupancy follows from the stored count.
module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  spq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output spq_pkg::out_t  out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_pkg::state_t    state_r, state_nxt;
  spq_pkg::in_t       req_r, req_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  spq_pkg::out_t      out_data_r, out_data_nxt;
  spq_pkg::cell_ctl_t ctl;
  logic               accept;
  logic [CW+spq_pkg::COUNT_W-1:0] count_ext;

  spq_pkg::entry_t cmp_entry, ins_entry;
  spq_pkg::entry_t cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_ins, cell_match, cell_occ;

  assign in_stall = (state_r != spq_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cmp_entry = '{handle: in_data.item_handle, kind: in_data.item_kind,
                       prio: in_data.item_priority};
  assign ins_entry = '{handle: req_r.item_handle, kind: req_r.item_kind,
                       prio: req_r.item_priority};

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_r);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (cell_occ[i]),
        .cmp_entry  (cmp_entry),
        .ins_entry  (ins_entry),
        .prev_entry (ins_entry),
        .next_entry ((CAPACITY > 1) ? cell_entry[(CAPACITY > 1) ? 1 : 0] : cell_entry[0]),
        .prev_ins   (1'b0),
        .entry      (cell_entry[i]),
        .ins        (cell_ins[i]),
        .match      (cell_match[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (cell_occ[i]),
        .cmp_entry  (cmp_entry),
        .ins_entry  (ins_entry),
        .prev_entry (cell_entry[i-1]),
        .next_entry (cell_entry[i]),
        .prev_ins   (cell_ins[i-1]),
        .entry      (cell_entry[i]),
        .ins        (cell_ins[i]),
        .match      (cell_match[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (cell_occ[i]),
        .cmp_entry  (cmp_entry),
        .ins_entry  (ins_entry),
        .prev_entry (cell_entry[i-1]),
        .next_entry (cell_entry[i+1]),
        .prev_ins   (cell_ins[i-1]),
        .entry      (cell_entry[i]),
        .ins        (cell_ins[i]),
        .match      (cell_match[i])
      );
    end
  end

  assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, count_nxt};

  // Sequencer: capture, then execute and load the result
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '{capture: accept, do_insert: 1'b0, do_remove: 1'b0};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          state_nxt = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        state_nxt    = spq_pkg::S_IDLE;
        out_data_nxt = '0;
        case (req_r.func)
          spq_pkg::FUNC_INSERT: begin
            if (req_r.item_handle == '0) begin
              out_data_nxt.status = spq_pkg::STAT_NULL;
            end else if (count_r >= CW'(CAPACITY)) begin
              out_data_nxt.status = spq_pkg::STAT_FULL;
            end else begin
              ctl.do_insert = 1'b1;
              count_nxt     = count_r + CW'(1);
            end
          end
          spq_pkg::FUNC_REMOVE: begin
            if (count_r == '0) begin
              out_data_nxt.status = spq_pkg::STAT_EMPTY;
            end else begin
              ctl.do_remove             = 1'b1;
              count_nxt                 = count_r - CW'(1);
              out_data_nxt.out_handle   = cell_entry[0].handle;
              out_data_nxt.out_kind     = cell_entry[0].kind;
              out_data_nxt.out_priority = cell_entry[0].prio;
            end
          end
          spq_pkg::FUNC_QUERY: begin
            out_data_nxt.found = (req_r.item_handle != '0) && (|cell_match);
          end
          default: begin
          end
        endcase
        out_data_nxt.count = count_ext[spq_pkg::COUNT_W-1:0];
        out_valid_nxt      = 1'b1;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stored count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count above capacity");

  // The output register is free whenever a transaction executes
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spq_pkg::S_EXEC |-> !out_valid_r)
    else $error("result register busy during execute");

  // An accepted transaction executes in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == spq_pkg::S_EXEC)
    else $error("accepted transaction did not execute");

  // A count change only happens when a result is produced
  a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> out_valid_r)
    else $error("count changed without a result");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the stable minimum priority queue unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused operation selector: no change, status ok
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned COUNT_W   = spq_pkg::COUNT_W;
  localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_BLOCKS = 20;
  localparam int BLOCK_ITEMS   = 75;
  localparam int DRAIN_CYCLES  = 8;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  spq_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  spq_pkg::out_t  out_data;

  stable_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed stimulus row: op sent reps times, optional hand-typed reply
  typedef struct {
    spq_pkg::in_t  op;
    int            reps;
    bit            typed;
    spq_pkg::out_t want;
  } dir_row_t;

  dir_row_t        dir_table[$];
  spq_pkg::entry_t queued_entries[$];   // predictor copy of the sorted store
  spq_pkg::out_t   reply_queue[$];      // replies still owed by the block
  int              mismatch_count = 0;
  int              replies_seen   = 0;
  bit              no_idle        = 1'b0;
  bit              hold_req       = 1'b0;

  function automatic void add_row(input logic [1:0] func, input logic [31:0] handle,
                                  input logic [15:0] kind, input logic signed [31:0] prio,
                                  input int reps, input bit typed = 1'b0,
                                  input spq_pkg::out_t want = '0);
    dir_row_t row;
    row.op.func          = func;
    row.op.item_handle   = handle;
    row.op.item_kind     = kind;
    row.op.item_priority = prio;
    row.reps             = reps;
    row.typed            = typed;
    row.want             = want;
    dir_table.push_back(row);
  endfunction

  // Apply one operation to the predictor store and return the reply
  function automatic spq_pkg::out_t predict_reply(input spq_pkg::in_t op);
    spq_pkg::out_t   r;
    spq_pkg::entry_t e;
    int              pos;
    r = '0;
    case (op.func)
      spq_pkg::FUNC_INSERT: begin
        if (op.item_handle == 32'd0) begin
          r.status = spq_pkg::STAT_NULL;
        end else if (queued_entries.size() >= CAPACITY) begin
          r.status = spq_pkg::STAT_FULL;
        end else begin
          // stable: goes after every entry with priority <= its own
          pos = 0;
          while (pos < queued_entries.size() &&
                 $signed(queued_entries[pos].prio) <= $signed(op.item_priority))
            pos++;
          e.handle = op.item_handle;
          e.kind   = op.item_kind;
          e.prio   = op.item_priority;
          queued_entries.insert(pos, e);
        end
      end
      spq_pkg::FUNC_REMOVE: begin
        if (queued_entries.size() == 0) begin
          r.status = spq_pkg::STAT_EMPTY;
        end else begin
          e = queued_entries.pop_front();
          r.out_handle   = e.handle;
          r.out_kind     = e.kind;
          r.out_priority = e.prio;
        end
      end
      spq_pkg::FUNC_QUERY: begin
        if (op.item_handle != 32'd0) begin
          foreach (queued_entries[i])
            if (queued_entries[i].handle == op.item_handle) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(queued_entries.size());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, reply %0d: %s", $time, replies_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input spq_pkg::out_t got, input spq_pkg::out_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.out_handle !== want.out_handle)
      report_mismatch($sformatf("handle got %h want %h", got.out_handle, want.out_handle));
    if (got.out_kind !== want.out_kind)
      report_mismatch($sformatf("kind got %h want %h", got.out_kind, want.out_kind));
    if (got.out_priority !== want.out_priority)
      report_mismatch($sformatf("priority got %0d want %0d",
                                got.out_priority, want.out_priority));
    if (got.found !== want.found)
      report_mismatch($sformatf("found got %0d want %0d", got.found, want.found));
    if (got.count !== want.count)
      report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
  endtask

  // Offer one transaction after a random gap; predict on acceptance
  task automatic send_op(input spq_pkg::in_t op, input bit typed, input spq_pkg::out_t want);
    int            gap;
    spq_pkg::out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    predicted = predict_reply(op);
    reply_queue.push_back(typed ? want : predicted);
  endtask

  function automatic logic [31:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'd0;
    if (roll <= 3 && queued_entries.size() != 0)
      return queued_entries[$urandom_range(0, queued_entries.size() - 1)].handle;
    if (roll <= 6) return 32'($urandom_range(1, 40));
    return 32'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_priority();
    int roll;
    int near;
    roll = $urandom_range(0, 9);
    near = $urandom_range(0, 6);
    if (roll == 0) return PRIO_MIN;
    if (roll == 1) return PRIO_MAX;
    if (roll <= 5) return near - 3;   // narrow band, many ties
    return 32'($urandom);
  endfunction

  function automatic spq_pkg::in_t random_op(input int ins_w, input int rem_w);
    spq_pkg::in_t op;
    int           roll;
    op.item_handle   = pick_handle();
    op.item_kind     = 16'($urandom);
    op.item_priority = pick_priority();
    roll = $urandom_range(0, 99);
    if (roll < 3)                      op.func = FUNC_NONE;
    else if (roll < 3 + ins_w)         op.func = spq_pkg::FUNC_INSERT;
    else if (roll < 3 + ins_w + rem_w) op.func = spq_pkg::FUNC_REMOVE;
    else                               op.func = spq_pkg::FUNC_QUERY;
    return op;
  endfunction

  // Stimulus: reset, directed table, then random blocks
  initial begin : stimulus
    int ins_w;
    int rem_w;
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_EMPTY, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd0});
    add_row(spq_pkg::FUNC_QUERY, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd0});
    add_row(spq_pkg::FUNC_INSERT, 32'd0, 16'hffff, PRIO_MIN, 1, 1'b1,
            '{spq_pkg::STAT_NULL, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd0});
    add_row(spq_pkg::FUNC_INSERT, 32'd1, 16'h0000, PRIO_MAX, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd1});
    add_row(spq_pkg::FUNC_INSERT, 32'hffff_ffff, 16'hffff, PRIO_MIN, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd2});
    // equal priorities, plus a duplicate handle
    add_row(spq_pkg::FUNC_INSERT, 32'd5, 16'h1234, 32'sd0, 1);
    add_row(spq_pkg::FUNC_INSERT, 32'd6, 16'h2345, 32'sd0, 1);
    add_row(spq_pkg::FUNC_INSERT, 32'd7, 16'h3456, 32'sd0, 1);
    add_row(spq_pkg::FUNC_INSERT, 32'd6, 16'h4567, 32'sd0, 1);
    add_row(spq_pkg::FUNC_QUERY, 32'd6, 16'd0, 32'sd0, 1);
    add_row(spq_pkg::FUNC_QUERY, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd6});
    add_row(spq_pkg::FUNC_QUERY, 32'hdead_beef, 16'd0, 32'sd0, 1);
    add_row(FUNC_NONE, 32'hffff_ffff, 16'hffff, PRIO_MAX, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd6});
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'hffff_ffff, 16'hffff, PRIO_MIN, 1'b0, 7'd5});
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, 4);
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd1, 16'h0000, PRIO_MAX, 1'b0, 7'd0});
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_EMPTY, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd0});
    // fill to capacity, then full and null-on-full
    add_row(spq_pkg::FUNC_INSERT, 32'h100, 16'h5a5a, 32'sd3, CAPACITY);
    add_row(spq_pkg::FUNC_INSERT, 32'h200, 16'ha5a5, 32'sd1, 1, 1'b1,
            '{spq_pkg::STAT_FULL, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd64});
    add_row(spq_pkg::FUNC_INSERT, 32'd0, 16'ha5a5, 32'sd1, 1, 1'b1,
            '{spq_pkg::STAT_NULL, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd64});
    add_row(spq_pkg::FUNC_QUERY, 32'h100, 16'd0, 32'sd0, 1);
    add_row(spq_pkg::FUNC_REMOVE, 32'd0, 16'd0, 32'sd0, CAPACITY + 1);
    add_row(spq_pkg::FUNC_QUERY, 32'h100, 16'd0, 32'sd0, 1, 1'b1,
            '{spq_pkg::STAT_OK, 32'd0, 16'd0, 32'sd0, 1'b0, 7'd0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[r])
      repeat (dir_table[r].reps)
        send_op(dir_table[r].op, dir_table[r].typed, dir_table[r].want);

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      // now and then let everything drain before going on
      if (blk % 6 == 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (reply_queue.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 2))
        0:       begin ins_w = 65; rem_w = 20; end   // filling
        1:       begin ins_w = 20; rem_w = 65; end   // draining
        default: begin ins_w = 40; rem_w = 35; end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while we keep offering
      if (blk == 4 || blk == 13) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
      end
      repeat (BLOCK_ITEMS) send_op(random_op(ins_w, rem_w), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Result side stall pattern
  initial begin : receiver
    int hold;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check each accepted reply against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_queue.size() == 0) begin
        report_mismatch("reply with nothing expected");
      end else begin
        check_result(out_data, reply_queue.pop_front());
      end
      replies_seen++;
    end
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_unit.sv
tb/sv/tb.sv
